// File: hw/rtl/svds_pkg.sv
// shared types and constants of the string view delimiter splitter
`timescale 1ns / 1ps
`default_nettype none

package svds_pkg;

    // width of a position field on the result channel
    localparam int unsigned OUT_POS_W = 16;

    // split mode codes
    localparam logic [2:0] MODE_COMMA      = 3'd0;
    localparam logic [2:0] MODE_SPACE      = 3'd1;
    localparam logic [2:0] MODE_LINE_BREAK = 3'd2;
    localparam logic [2:0] MODE_WHITESPACE = 3'd3;
    localparam logic [2:0] MODE_STRING     = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_SPLIT_MODE   = 2'd0;
    localparam logic [1:0] REG_DELIM_LENGTH = 2'd1;
    localparam logic [1:0] REG_DELIM_BYTES  = 2'd2;
    localparam logic [1:0] REG_VIEW_START   = 2'd3;

    // characters the fixed modes split on
    localparam logic [7:0] CHAR_COMMA      = 8'h2C;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_LINE_BREAK = 8'h0A;

    // one character of the view
    typedef struct packed {
        logic [7:0] symbol;
        logic       has_symbol;
        logic       last_symbol;
    } t_in_item;

    // one segment of the view
    typedef struct packed {
        logic [OUT_POS_W-1:0] seg_start;
        logic [OUT_POS_W-1:0] seg_end;
        logic                 last_segment;
    } t_out_item;

endpackage

`default_nettype wire

// File: hw/rtl/string_view_delimiter_splitter_core.sv
// top level of the string view delimiter splitter
`timescale 1ns / 1ps
`default_nettype none

// channel      direction  handshake            payload
// input item   in         i_valid / o_ready    i_data  (svds_pkg::t_in_item)
// result item  out        o_valid / i_ready    o_data  (svds_pkg::t_out_item)
// config       in         psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// each character is handled in the cycle of its transfer: the segment logic
// and the parallel window compare feed a four-entry result queue directly
// o_ready is high while the queue has room for two results, so items that
// give at most one result each flow at one per cycle while i_ready is high;
// an item that gives two results sends them through the one result port in turn
// synchronous active-low reset empties the queue and starts a new view
// a stalled result port fills the queue and then holds o_ready low

module string_view_delimiter_splitter_core #(
    parameter int unsigned MAX_DELIM_BYTES = 8,
    parameter int unsigned POS_WIDTH       = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // input items
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire svds_pkg::t_in_item i_data,
    // result items
    output logic                    o_valid,
    input  wire                     i_ready,
    output svds_pkg::t_out_item     o_data,
    // configuration port
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [4:0]              paddr,
    input  wire  [63:0]             pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);

    localparam int unsigned WIN_W      = 8 * MAX_DELIM_BYTES;
    localparam int unsigned FILL_W     = $clog2(MAX_DELIM_BYTES + 1);
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    // position to result field width
    function automatic logic [svds_pkg::OUT_POS_W-1:0] pos_out(
        input logic [POS_WIDTH-1:0] p
    );
        logic [31:0] w;
        begin
            w = 32'(p);
            return w[svds_pkg::OUT_POS_W-1:0];
        end
    endfunction

    // configuration registers
    logic [2:0]           r_split_mode;
    logic [3:0]           r_delim_length;
    logic [63:0]          r_delim_bytes;
    logic [POS_WIDTH-1:0] r_view_start;

    // view state
    logic [WIN_W-1:0]     r_window, n_window;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [POS_WIDTH-1:0] r_cur, n_cur;
    logic [POS_WIDTH-1:0] r_seg, n_seg;

    // result queue
    svds_pkg::t_out_item  r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]     r_head, r_tail;
    logic [CNT_W-1:0]     r_count;

    logic cfg_wr;
    logic in_xfer;
    logic out_xfer;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign o_ready  = (r_count < CNT_W'(FIFO_DEPTH - 1));
    assign o_valid  = (r_count != '0);
    assign o_data   = r_fifo[r_head];
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;

    // register read back
    always_comb begin
        case (paddr[4:3])
            svds_pkg::REG_SPLIT_MODE:   prdata = 64'(r_split_mode);
            svds_pkg::REG_DELIM_LENGTH: prdata = 64'(r_delim_length);
            svds_pkg::REG_DELIM_BYTES:  prdata = r_delim_bytes;
            svds_pkg::REG_VIEW_START:   prdata = 64'(r_view_start);
            default:                    prdata = '0;
        endcase
    end

    // delimiter length in use, held at the window size
    logic [FILL_W-1:0] len_used;
    assign len_used = (r_delim_length > 4'(MAX_DELIM_BYTES)) ?
                      FILL_W'(MAX_DELIM_BYTES) : FILL_W'(r_delim_length);

    // shifted window and fill, then a compare for every delimiter length
    logic [WIN_W-1:0]         win_shift;
    logic [FILL_W-1:0]        fill_inc;
    logic [MAX_DELIM_BYTES:0] len_match;
    logic                     str_match;

    assign win_shift = (r_window << 8) | WIN_W'(i_data.symbol);
    assign fill_inc  = (r_fill < FILL_W'(MAX_DELIM_BYTES)) ? r_fill + 1'b1 : r_fill;

    always_comb begin
        len_match[0] = 1'b0;
        for (int l = 1; l <= MAX_DELIM_BYTES; l++) begin
            len_match[l] = 1'b1;
            for (int k = 0; k < MAX_DELIM_BYTES; k++) begin
                if (k < l) begin
                    if (win_shift[8*(l-1-k) +: 8] != r_delim_bytes[8*k +: 8]) begin
                        len_match[l] = 1'b0;
                    end
                end
            end
        end
    end

    assign str_match = (len_used != '0) && (fill_inc >= len_used) && len_match[len_used];

    // character mode match
    logic chr_match;
    always_comb begin
        case (r_split_mode)
            svds_pkg::MODE_COMMA:      chr_match = (i_data.symbol == svds_pkg::CHAR_COMMA);
            svds_pkg::MODE_SPACE:      chr_match = (i_data.symbol == svds_pkg::CHAR_SPACE);
            svds_pkg::MODE_LINE_BREAK: chr_match = (i_data.symbol == svds_pkg::CHAR_LINE_BREAK);
            svds_pkg::MODE_WHITESPACE: chr_match = (i_data.symbol == svds_pkg::CHAR_SPACE) ||
                                                   (i_data.symbol == svds_pkg::CHAR_LINE_BREAK);
            default:                   chr_match = 1'b0;
        endcase
    end

    // segment logic for one transfer
    logic [POS_WIDTH-1:0] pos_next;
    logic [POS_WIDTH-1:0] len_ext;
    logic [POS_WIDTH-1:0] a_start, a_end, b_start, b_end;
    logic                 a_valid;
    logic                 b_valid;
    logic                 is_string;

    assign pos_next  = (&r_cur) ? r_cur : r_cur + 1'b1;
    assign len_ext   = POS_WIDTH'(len_used);
    assign is_string = (r_split_mode == svds_pkg::MODE_STRING);

    always_comb begin
        n_window = r_window;
        n_fill   = r_fill;
        n_cur    = r_cur;
        n_seg    = r_seg;
        a_valid  = 1'b0;
        a_start  = r_seg;
        a_end    = r_cur;
        b_valid  = 1'b0;
        if (i_data.has_symbol) begin
            if (is_string) begin
                n_window = win_shift;
                n_fill   = fill_inc;
                if (str_match) begin
                    a_valid = 1'b1;
                    a_end   = (pos_next >= len_ext) ? pos_next - len_ext : '0;
                    n_seg   = pos_next;
                    n_fill  = '0;
                end
            end else if (chr_match) begin
                a_valid = 1'b1;
                a_end   = r_cur;
                n_seg   = pos_next;
            end
            n_cur = pos_next;
        end
        b_start = n_seg;
        b_end   = n_cur;
        if (i_data.last_symbol) begin
            b_valid  = 1'b1;
            n_window = '0;
            n_fill   = '0;
            n_cur    = r_view_start;
            n_seg    = r_view_start;
        end
    end

    // results in queue form, an end below its start is raised to the start
    svds_pkg::t_out_item res_a, res_b, push_first;
    logic [1:0]          push_cnt;

    always_comb begin
        res_a.seg_start    = pos_out(a_start);
        res_a.seg_end      = pos_out((a_end < a_start) ? a_start : a_end);
        res_a.last_segment = 1'b0;
        res_b.seg_start    = pos_out(b_start);
        res_b.seg_end      = pos_out((b_end < b_start) ? b_start : b_end);
        res_b.last_segment = 1'b1;
        push_first         = a_valid ? res_a : res_b;
        push_cnt           = in_xfer ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
    end

    // configuration and view state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_mode   <= svds_pkg::MODE_COMMA;
            r_delim_length <= 4'd1;
            r_delim_bytes  <= 64'd44;
            r_view_start   <= '0;
            r_window       <= '0;
            r_fill         <= '0;
            r_cur          <= '0;
            r_seg          <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                svds_pkg::REG_SPLIT_MODE:   r_split_mode   <= pwdata[2:0];
                svds_pkg::REG_DELIM_LENGTH: r_delim_length <= pwdata[3:0];
                svds_pkg::REG_DELIM_BYTES:  r_delim_bytes  <= pwdata;
                svds_pkg::REG_VIEW_START: begin
                    r_view_start <= POS_WIDTH'(pwdata[15:0]);
                    r_cur        <= POS_WIDTH'(pwdata[15:0]);
                    r_seg        <= POS_WIDTH'(pwdata[15:0]);
                    r_window     <= '0;
                    r_fill       <= '0;
                end
                default: ;
            endcase
        end else if (in_xfer) begin
            r_window <= n_window;
            r_fill   <= n_fill;
            r_cur    <= n_cur;
            r_seg    <= n_seg;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_fifo[r_tail] <= push_first;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[r_tail + 1'b1] <= res_b;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + PTR_W'(push_cnt);
            r_head  <= r_head + PTR_W'(out_xfer);
            r_count <= r_count + CNT_W'(push_cnt) - CNT_W'(out_xfer);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/svds_checker.sv
// port checker for the string view delimiter splitter and its bind
`timescale 1ns / 1ps
`default_nettype none

module svds_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      o_valid,
    input wire                      i_ready,
    input wire                      o_ready,
    input wire svds_pkg::t_out_item o_data
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data))
        else $error("result changed while stalled");

    // a segment never ends before it starts
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.seg_end >= o_data.seg_start)
        else $error("segment end below start");

    // reset leaves the queue empty and ready for input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("queue not empty after reset");

endmodule

bind string_view_delimiter_splitter_core svds_checker u_svds_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_ready (o_ready),
    .o_data  (o_data)
);

`default_nettype wire
